// File: hw/rtl/tclc_pkg.sv
// Shared types and constants for the three-car chase block.
// Used by tclc_div, tclc_front, tclc_back and three_car_led_chase.
`timescale 1ns / 1ps

package tclc_pkg;

  // Field widths
  localparam int LEN_W     = 11;  // strip length, 0..1024
  localparam int POS_W     = 10;  // pixel position, 0..1023
  localparam int CAR_W     = 9;   // car length, gap and spacing, up to 341
  localparam int SUM_W     = LEN_W + 1;
  localparam int COL_W     = 32;
  localparam int TIME_W    = 32;
  localparam int SET_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CARS  = 3;

  // Scaled numerators of the map steps: largest is 255 * 340
  localparam int NUM_W = 17;

  // Remainder unit: dividend is the head position, divisor the strip length
  localparam int DIV_W = POS_W;
  localparam int DVS_W = LEN_W;

  // Constant divides by reciprocal multiply:
  // x / 255 == (x * 131587) >> 25 for x < 132623, x / 3 == (x * 683) >> 11 for x < 2048
  localparam int RCP255_M = 131587;
  localparam int RCP255_S = 25;
  localparam int RCP3_M   = 683;
  localparam int RCP3_S   = 11;

  localparam logic [LEN_W-1:0] MAX_LEDS = 11'd1024;

  localparam int IVL_BASE  = 180;
  localparam int IVL_SPAN  = 170;

  localparam logic [SET_W-1:0] SPEED_RST   = 8'd128;
  localparam logic [SET_W-1:0] CAR_LEN_RST = 8'd128;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_SET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_THREE = 3'd6;

  // Operation codes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    K_NOP   = 2'd0,
    K_FRAME = 2'd1,
    K_QUERY = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [TIME_W-1:0]  now_ms;
    logic [POS_W-1:0]   pixel;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]                   len;
    logic [SET_W-1:0]                   speed;
    logic [SET_W-1:0]                   car_len_set;
    logic [SET_W-1:0]                   gap_set;
    logic [NUM_CARS-1:0][COL_W-1:0]     color;
  } cfg_t;

endpackage

// File: hw/rtl/tclc_div.sv
// Restoring divider giving the remainder, one bit per cycle.
// Depends on tclc_pkg for operand widths.
`timescale 1ns / 1ps

module tclc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tclc_pkg::DIV_W-1:0]    dividend,
  input  logic [tclc_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [tclc_pkg::DVS_W-1:0]    rem
);

  localparam int CNT_W = $clog2(tclc_pkg::DIV_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [tclc_pkg::DIV_W-1:0]    quot_r, quot_nxt;
  logic [tclc_pkg::DVS_W-1:0]    rem_r, rem_nxt;
  logic [tclc_pkg::DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [tclc_pkg::DVS_W:0]      shifted, trial;
  logic                          fits;

  assign shifted = {rem_r, quot_r[tclc_pkg::DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial[tclc_pkg::DVS_W-1:0] : shifted[tclc_pkg::DVS_W-1:0];
      quot_nxt = {quot_r[tclc_pkg::DIV_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(tclc_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: hw/rtl/tclc_front.sv
// Front end: takes input words, sorts them into frame / query / no-op,
// and holds them in a two-entry queue for the back end. Uses tclc_pkg.
`timescale 1ns / 1ps

module tclc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tclc_pkg::LEN_W-1:0]    cfg_len,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [tclc_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [tclc_pkg::POS_W-1:0]    in_pixel_index,
  output logic                          q_valid,
  output tclc_pkg::item_t               q_item,
  input  logic                          q_pop
);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  tclc_pkg::item_t   mem_r [QDEPTH];
  tclc_pkg::item_t   item_in;
  tclc_pkg::kind_t   kind;
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              push;

  // Out-of-strip queries and anything on an empty strip need no work
  always_comb begin
    if (cfg_len == '0) begin
      kind = tclc_pkg::K_NOP;
    end else if (in_op == tclc_pkg::OP_FRAME) begin
      kind = tclc_pkg::K_FRAME;
    end else if (tclc_pkg::LEN_W'(in_pixel_index) < cfg_len) begin
      kind = tclc_pkg::K_QUERY;
    end else begin
      kind = tclc_pkg::K_NOP;
    end
  end

  assign item_in  = '{kind: kind, now_ms: in_now_ms, pixel: in_pixel_index};
  assign in_ready = (cnt_r != QCW'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (q_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// File: hw/rtl/tclc_back.sv
// Back end: chase state, derived car geometry and the result register.
// Depends on tclc_pkg and tclc_div.
`timescale 1ns / 1ps

module tclc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tclc_pkg::cfg_t                cfg,
  input  logic                          cfg_touch,
  input  logic                          q_valid,
  input  tclc_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tclc_pkg::POS_W-1:0]    out_head_position,
  output logic [tclc_pkg::COL_W-1:0]    out_pixel_color
);

  localparam int LEN_W  = tclc_pkg::LEN_W;
  localparam int POS_W  = tclc_pkg::POS_W;
  localparam int CAR_W  = tclc_pkg::CAR_W;
  localparam int SUM_W  = tclc_pkg::SUM_W;
  localparam int COL_W  = tclc_pkg::COL_W;
  localparam int TIME_W = tclc_pkg::TIME_W;
  localparam int NUM_W  = tclc_pkg::NUM_W;
  localparam int DIV_W  = tclc_pkg::DIV_W;
  localparam int DVS_W  = tclc_pkg::DVS_W;
  localparam int NCARS  = tclc_pkg::NUM_CARS;
  localparam int P255_W = NUM_W + 18;
  localparam int P3_W   = LEN_W + 10;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DINT   = 11'b000_0000_0010,
    S_DCMAX  = 11'b000_0000_0100,
    S_DCLEN  = 11'b000_0000_1000,
    S_DMGAP  = 11'b000_0001_0000,
    S_DTHIRD = 11'b000_0010_0000,
    S_DDGAP  = 11'b000_0100_0000,
    S_DORG   = 11'b000_1000_0000,
    S_DST1   = 11'b001_0000_0000,
    S_DST2   = 11'b010_0000_0000,
    S_QUERY  = 11'b100_0000_0000
  } bstate_t;

  bstate_t             state_r, state_nxt;
  logic                dirty_r, dirty_nxt;
  logic                div_wait_r, div_wait_nxt;
  logic                step_r, step_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic                started_r, started_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [POS_W-1:0]    head_r, head_nxt;
  logic [POS_W-1:0]    origin_r, origin_nxt;
  logic [POS_W-1:0]    start_r [NCARS];
  logic [POS_W-1:0]    start_nxt [NCARS];
  logic [POS_W-1:0]    dist_r [NCARS];
  logic [POS_W-1:0]    dist_nxt [NCARS];
  logic [7:0]          interval_r, interval_nxt;
  logic [CAR_W-1:0]    cmax_r, cmax_nxt;
  logic [CAR_W-1:0]    clen_r, clen_nxt;
  logic [CAR_W-1:0]    maxgap_r, maxgap_nxt;
  logic [CAR_W-1:0]    third_r, third_nxt;
  logic [CAR_W-1:0]    gap_r, gap_nxt;
  logic [CAR_W-1:0]    spacing_r, spacing_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_head_r, out_head_nxt;
  logic [COL_W-1:0]    out_color_r, out_color_nxt;

  logic                out_free, out_load;
  logic [POS_W-1:0]    out_head_d;
  logic [COL_W-1:0]    out_color_d;
  logic                derive_go, dirty_set;
  logic [LEN_W-1:0]    len;
  logic                len_nz;
  logic [TIME_W-1:0]   elapsed;
  logic                advance;
  logic [POS_W-1:0]    origin_inc;
  logic [LEN_W-1:0]    trip_clen;
  logic [P255_W-1:0]   prod255;
  logic [P3_W-1:0]     prod3;
  logic [CAR_W-1:0]    q255, q255_inc, q3;

  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs, div_rem;

  // (a + b) mod l, for a < l and b <= l
  function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] a,
                                                input logic [CAR_W-1:0] b,
                                                input logic [LEN_W-1:0] l);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(l)) begin
      s = s - SUM_W'(l);
    end
    return s[POS_W-1:0];
  endfunction

  // (p - s) mod l, for p < l and s < l
  function automatic logic [POS_W-1:0] ring_dist(input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] s,
                                                 input logic [LEN_W-1:0] l);
    logic [SUM_W-1:0] d;
    d = SUM_W'(p) - SUM_W'(s);
    if (p < s) begin
      d = d + SUM_W'(l);
    end
    return d[POS_W-1:0];
  endfunction

  tclc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign len        = cfg.len;
  assign len_nz     = (len != '0);
  assign out_free   = !out_valid_r || out_ready;
  assign elapsed    = q_item.now_ms - last_r;
  assign advance    = started_r && (elapsed >= TIME_W'(interval_r));
  assign origin_inc = wrap_add(origin_r, CAR_W'(1), len);
  assign trip_clen  = LEN_W'({clen_r, 1'b0}) + LEN_W'(clen_r);
  assign div_dvd    = head_r;
  assign div_dvs    = len;

  // numerator registered in num_r while step_r is low, quotient used while step_r is high
  assign prod255  = P255_W'(num_r) * P255_W'(tclc_pkg::RCP255_M);
  assign prod3    = P3_W'(num_r[LEN_W-1:0]) * P3_W'(tclc_pkg::RCP3_M);
  assign q255     = CAR_W'(prod255 >> tclc_pkg::RCP255_S);
  assign q3       = CAR_W'(prod3 >> tclc_pkg::RCP3_S);
  assign q255_inc = q255 + 1'b1;

  always_comb begin
    num_nxt = '0;
    case (state_r)
      S_DINT: begin
        num_nxt = NUM_W'(cfg.speed) * NUM_W'(tclc_pkg::IVL_SPAN);
      end
      S_DCMAX: begin
        num_nxt = (len > LEN_W'(tclc_pkg::NUM_CARS)) ?
                  NUM_W'(len - LEN_W'(tclc_pkg::NUM_CARS)) : '0;
      end
      S_DCLEN: begin
        num_nxt = NUM_W'(cfg.car_len_set) * NUM_W'(cmax_r - 1'b1);
      end
      S_DMGAP: begin
        num_nxt = (len > trip_clen) ? NUM_W'(len - trip_clen) : '0;
      end
      S_DTHIRD: begin
        num_nxt = NUM_W'(len);
      end
      S_DDGAP: begin
        num_nxt = NUM_W'(cfg.gap_set) * NUM_W'(third_r - 1'b1);
      end
      default: begin
        num_nxt = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = 1'b0;
    started_nxt  = started_r;
    last_nxt     = last_r;
    head_nxt     = head_r;
    origin_nxt   = origin_r;
    interval_nxt = interval_r;
    cmax_nxt     = cmax_r;
    clen_nxt     = clen_r;
    maxgap_nxt   = maxgap_r;
    third_nxt    = third_r;
    gap_nxt      = gap_r;
    spacing_nxt  = spacing_r;
    for (int c = 0; c < NCARS; c++) begin
      start_nxt[c] = start_r[c];
      dist_nxt[c]  = dist_r[c];
    end
    q_pop       = 1'b0;
    div_start   = 1'b0;
    derive_go   = 1'b0;
    dirty_set   = 1'b0;
    out_load    = 1'b0;
    out_head_d  = origin_r;
    out_color_d = '0;

    case (state_r)
      S_IDLE: begin
        if (dirty_r) begin
          derive_go = 1'b1;
          if (len_nz) begin
            state_nxt = S_DINT;
          end
        end else if (q_valid) begin
          case (q_item.kind)
            tclc_pkg::K_FRAME: begin
              if (out_free) begin
                q_pop    = 1'b1;
                out_load = 1'b1;
                if (!started_r) begin
                  // first frame: restart from pixel 0, car starts need redoing
                  started_nxt = 1'b1;
                  last_nxt    = q_item.now_ms;
                  head_nxt    = '0;
                  origin_nxt  = '0;
                  dirty_set   = 1'b1;
                  out_head_d  = '0;
                end else if (advance) begin
                  last_nxt   = q_item.now_ms;
                  head_nxt   = origin_inc;
                  origin_nxt = origin_inc;
                  for (int c = 0; c < NCARS; c++) begin
                    start_nxt[c] = wrap_add(start_r[c], CAR_W'(1), len);
                  end
                  out_head_d = origin_inc;
                end
              end
            end
            tclc_pkg::K_QUERY: begin
              q_pop     = 1'b1;
              state_nxt = S_QUERY;
              for (int c = 0; c < NCARS; c++) begin
                dist_nxt[c] = ring_dist(q_item.pixel, start_r[c], len);
              end
            end
            default: begin
              if (out_free) begin
                q_pop      = 1'b1;
                out_load   = 1'b1;
                out_head_d = len_nz ? origin_r : head_r;
              end
            end
          endcase
        end
      end
      S_DINT: begin
        step_nxt = !step_r;
        if (step_r) begin
          interval_nxt = 8'(tclc_pkg::IVL_BASE) - q255[7:0];
          state_nxt    = S_DCMAX;
        end
      end
      S_DCMAX: begin
        step_nxt = !step_r;
        if (step_r) begin
          cmax_nxt  = (q3 == '0) ? CAR_W'(1) : q3;
          state_nxt = S_DCLEN;
        end
      end
      S_DCLEN: begin
        step_nxt = !step_r;
        if (step_r) begin
          clen_nxt  = q255_inc;
          state_nxt = S_DMGAP;
        end
      end
      S_DMGAP: begin
        step_nxt = !step_r;
        if (step_r) begin
          maxgap_nxt = q3;
          state_nxt  = S_DTHIRD;
        end
      end
      S_DTHIRD: begin
        step_nxt = !step_r;
        if (step_r) begin
          third_nxt = (q3 == '0) ? CAR_W'(1) : q3;
          state_nxt = S_DDGAP;
        end
      end
      S_DDGAP: begin
        step_nxt = !step_r;
        if (step_r) begin
          if (maxgap_r == '0) begin
            gap_nxt = '0;
          end else begin
            gap_nxt = (q255_inc < maxgap_r) ? q255_inc : maxgap_r;
          end
          state_nxt = S_DORG;
        end
      end
      S_DORG: begin
        div_start = !div_wait_r;
        if (div_done) begin
          origin_nxt   = div_rem[POS_W-1:0];
          start_nxt[0] = div_rem[POS_W-1:0];
          spacing_nxt  = clen_r + gap_r;
          state_nxt    = S_DST1;
        end
      end
      S_DST1: begin
        start_nxt[1] = wrap_add(start_r[0], spacing_r, len);
        state_nxt    = S_DST2;
      end
      S_DST2: begin
        start_nxt[2] = wrap_add(start_r[1], spacing_r, len);
        state_nxt    = S_IDLE;
      end
      S_QUERY: begin
        if (out_free) begin
          out_load = 1'b1;
          // later cars paint over earlier ones
          for (int c = 0; c < NCARS; c++) begin
            if (cfg.color[c] != '0 && dist_r[c] < POS_W'(clen_r)) begin
              out_color_d = cfg.color[c];
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign div_wait_nxt  = (div_wait_r || div_start) && !div_done;
  assign dirty_nxt     = cfg_touch || dirty_set || (dirty_r && !derive_go);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);
  assign out_head_nxt  = out_load ? out_head_d : out_head_r;
  assign out_color_nxt = out_load ? out_color_d : out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dirty_r     <= 1'b1;
      div_wait_r  <= 1'b0;
      step_r      <= 1'b0;
      started_r   <= 1'b0;
      last_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      div_wait_r  <= div_wait_nxt;
      step_r      <= step_nxt;
      started_r   <= started_nxt;
      last_r      <= last_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r       <= num_nxt;
    origin_r    <= origin_nxt;
    interval_r  <= interval_nxt;
    cmax_r      <= cmax_nxt;
    clen_r      <= clen_nxt;
    maxgap_r    <= maxgap_nxt;
    third_r     <= third_nxt;
    gap_r       <= gap_nxt;
    spacing_r   <= spacing_nxt;
    out_head_r  <= out_head_nxt;
    out_color_r <= out_color_nxt;
    for (int c = 0; c < NCARS; c++) begin
      start_r[c] <= start_nxt[c];
      dist_r[c]  <= dist_nxt[c];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_head_position = out_head_r;
  assign out_pixel_color   = out_color_r;

  a_origin_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !dirty_r && len_nz) |-> (LEN_W'(origin_r) < len))
    else $error("head origin outside strip while geometry is current");

  a_dist_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUERY) |-> (LEN_W'(dist_r[0]) < len && LEN_W'(dist_r[1]) < len &&
                              LEN_W'(dist_r[2]) < len))
    else $error("car distance outside strip");

  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_wait_r)
    else $error("divider finished with no request outstanding");

endmodule

// File: hw/rtl/three_car_led_chase.sv
// Top level of the three-car chase: configuration registers, front end and back end.
// Depends on tclc_pkg, tclc_front, tclc_back (and tclc_div through the back end).
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Word
// in_      input      in_valid / in_ready    op, now_ms, pixel_index
// out_     output     out_valid / out_ready  head_position, pixel_color
// cfg_     input      cfg_valid / cfg_ready  index, data (always ready)
//
// In the back end a frame word is handled in S_IDLE alone, a pixel query in S_IDLE then S_QUERY.
// A write to registers 0..3, or the first frame, triggers on a non-empty strip a
// geometry recompute (six reciprocal steps, then a head modulo in the bit-serial
// divider) before the next word is processed. Reset is synchronous,
// active low; after reset the strip length is zero. Input and output stall
// independently through a two-entry queue and the output register.

module three_car_led_chase (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [tclc_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [tclc_pkg::POS_W-1:0]         in_pixel_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tclc_pkg::POS_W-1:0]         out_head_position,
  output logic [tclc_pkg::COL_W-1:0]         out_pixel_color,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tclc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int LEN_W = tclc_pkg::LEN_W;
  localparam int SET_W = tclc_pkg::SET_W;
  localparam int COL_W = tclc_pkg::COL_W;

  logic [LEN_W-1:0]   seg_len_r, seg_len_nxt;
  logic [SET_W-1:0]   speed_r, speed_nxt;
  logic [SET_W-1:0]   car_len_r, car_len_nxt;
  logic [SET_W-1:0]   gap_set_r, gap_set_nxt;
  logic [COL_W-1:0]   col_one_r, col_one_nxt;
  logic [COL_W-1:0]   col_two_r, col_two_nxt;
  logic [COL_W-1:0]   col_three_r, col_three_nxt;
  logic               cfg_wr, cfg_touch;
  logic [LEN_W-1:0]   eff_len;
  tclc_pkg::cfg_t     cfg;
  logic               q_valid, q_pop;
  tclc_pkg::item_t    q_item;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // length, speed and car-shape registers invalidate the derived geometry
  assign cfg_touch = cfg_wr && (cfg_index <= tclc_pkg::REG_GAP_SET);

  always_comb begin
    seg_len_nxt   = seg_len_r;
    speed_nxt     = speed_r;
    car_len_nxt   = car_len_r;
    gap_set_nxt   = gap_set_r;
    col_one_nxt   = col_one_r;
    col_two_nxt   = col_two_r;
    col_three_nxt = col_three_r;
    if (cfg_wr) begin
      case (cfg_index)
        tclc_pkg::REG_SEG_LEN:   seg_len_nxt   = cfg_data[LEN_W-1:0];
        tclc_pkg::REG_SPEED:     speed_nxt     = cfg_data[SET_W-1:0];
        tclc_pkg::REG_CAR_LEN:   car_len_nxt   = cfg_data[SET_W-1:0];
        tclc_pkg::REG_GAP_SET:   gap_set_nxt   = cfg_data[SET_W-1:0];
        tclc_pkg::REG_CAR_ONE:   col_one_nxt   = cfg_data;
        tclc_pkg::REG_CAR_TWO:   col_two_nxt   = cfg_data;
        tclc_pkg::REG_CAR_THREE: col_three_nxt = cfg_data;
        default: begin
          seg_len_nxt = seg_len_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r   <= '0;
      speed_r     <= tclc_pkg::SPEED_RST;
      car_len_r   <= tclc_pkg::CAR_LEN_RST;
      gap_set_r   <= '0;
      col_one_r   <= '0;
      col_two_r   <= '0;
      col_three_r <= '0;
    end else begin
      seg_len_r   <= seg_len_nxt;
      speed_r     <= speed_nxt;
      car_len_r   <= car_len_nxt;
      gap_set_r   <= gap_set_nxt;
      col_one_r   <= col_one_nxt;
      col_two_r   <= col_two_nxt;
      col_three_r <= col_three_nxt;
    end
  end

  assign eff_len = (seg_len_r > tclc_pkg::MAX_LEDS) ? tclc_pkg::MAX_LEDS : seg_len_r;

  assign cfg = '{len:         eff_len,
                 speed:       speed_r,
                 car_len_set: car_len_r,
                 gap_set:     gap_set_r,
                 color:       {col_three_r, col_two_r, col_one_r}};

  tclc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_len        (eff_len),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_now_ms      (in_now_ms),
    .in_pixel_index (in_pixel_index),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  tclc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cfg_touch         (cfg_touch),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_head_position (out_head_position),
    .out_pixel_color   (out_pixel_color)
  );

endmodule
